// ===== design/rase_pkg.sv =====
// rase_pkg: shared widths, reset values, register indexes, command/status structs
// and the arctangent table of the resolver angle and speed estimator
// no dependencies
`default_nettype none

package rase_pkg;

    // arctangent iteration count and counter width
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);

    // field widths
    localparam int IN_W      = 24;
    localparam int ANG_W     = 17;
    localparam int SPD_W     = 23;
    localparam int SUM_W     = 25;
    localparam int FACC_W    = 40;
    localparam int CORD_W    = 27;
    localparam int Z_W       = 18;
    localparam int WIN_W     = 8;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // register reset values
    localparam logic [WIN_W-1:0]  WINDOW_LEN_RST  = 8'd20;
    localparam logic [COEF_W-1:0] SPEED_SCALE_RST = 16'd125;
    localparam logic [COEF_W-1:0] FILTER_GAIN_RST = 16'd1311;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN  = 2'd0,
        CFG_SPEED_SCALE = 2'd1,
        CFG_FILTER_GAIN = 2'd2
    } t_cfg_idx;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic iterate;
        logic angle_upd;
        logic spd_mul;
        logic spd_upd;
        logic flt_mul;
        logic flt_sum;
        logic flt_upd;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic iter_last;
        logic window_hit;
    } t_sts;

    // atan(2^-i) in angle units (65536 = 180 degrees), rounded to nearest
    function automatic logic [14:0] atan_units(input logic [4:0] idx);
        logic [14:0] v;
        case (idx)
            5'd0:    v = 15'd16384;
            5'd1:    v = 15'd9672;
            5'd2:    v = 15'd5110;
            5'd3:    v = 15'd2594;
            5'd4:    v = 15'd1302;
            5'd5:    v = 15'd652;
            5'd6:    v = 15'd326;
            5'd7:    v = 15'd163;
            5'd8:    v = 15'd81;
            5'd9:    v = 15'd41;
            5'd10:   v = 15'd20;
            5'd11:   v = 15'd10;
            5'd12:   v = 15'd5;
            5'd13:   v = 15'd3;
            5'd14:   v = 15'd1;
            5'd15:   v = 15'd1;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/rase_if.sv =====
// rase channel interfaces: sample input, result output and register write
// depends on rase_pkg for field widths
`default_nettype none

interface rase_in_if import rase_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] sine_acc;
    logic signed [IN_W-1:0] cosine_acc;

    modport source (output valid, output sine_acc, output cosine_acc, input ready);
    modport sink   (input valid, input sine_acc, input cosine_acc, output ready);
endinterface

interface rase_out_if import rase_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ANG_W-1:0]        angle;
    logic                    speed_valid;
    logic signed [SPD_W-1:0] speed;
    logic signed [SPD_W-1:0] speed_filtered;

    modport source (output valid, output angle, output speed_valid, output speed,
                    output speed_filtered, input ready);
    modport sink   (input valid, input angle, input speed_valid, input speed,
                    input speed_filtered, output ready);
endinterface

interface rase_cfg_if import rase_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/rase_ctrl.sv =====
// rase_ctrl: sequencing state machine and output valid for the estimator
// depends on rase_pkg (t_cmd, t_sts)
`default_nettype none

module rase_ctrl import rase_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_ANGLE,
        S_SPD_MUL,
        S_SPD,
        S_FLT_MUL,
        S_FLT_SUM,
        S_FLT_UPD,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CORDIC;
                end
            end
            S_CORDIC: begin
                o_cmd.iterate = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                o_cmd.angle_upd = 1'b1;
                n_state = i_sts.window_hit ? S_SPD_MUL : S_OUT;
            end
            S_SPD_MUL: begin
                o_cmd.spd_mul = 1'b1;
                n_state       = S_SPD;
            end
            S_SPD: begin
                o_cmd.spd_upd = 1'b1;
                n_state       = S_FLT_MUL;
            end
            S_FLT_MUL: begin
                o_cmd.flt_mul = 1'b1;
                n_state       = S_FLT_SUM;
            end
            S_FLT_SUM: begin
                o_cmd.flt_sum = 1'b1;
                n_state       = S_FLT_UPD;
            end
            S_FLT_UPD: begin
                o_cmd.flt_upd = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== design/rase_dp.sv =====
// rase_dp: registers, shift-add arctangent, step unwrap, speed and filter arithmetic
// depends on rase_pkg (widths, t_cmd, t_sts, atan_units)
`default_nettype none

module rase_dp import rase_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_sts                        o_sts,
    input  wire logic signed [IN_W-1:0] i_sine_acc,
    input  wire logic signed [IN_W-1:0] i_cosine_acc,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]   i_cfg_data,
    output logic [ANG_W-1:0]            o_angle,
    output logic                        o_speed_valid,
    output logic signed [SPD_W-1:0]     o_speed,
    output logic signed [SPD_W-1:0]     o_speed_filtered
);

    // configuration
    logic [WIN_W-1:0]  r_window_len;
    logic [COEF_W-1:0] r_speed_scale;
    logic [COEF_W-1:0] r_filter_gain;

    // state
    logic [ANG_W-1:0]         r_prev;
    logic signed [SUM_W-1:0]  r_sum;
    logic [WIN_W-1:0]         r_count;
    logic signed [SPD_W-1:0]  r_speed;
    logic signed [FACC_W-1:0] r_facc;

    // per-item working registers
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [Z_W-1:0]    r_z;
    logic [ITER_W-1:0]        r_iter;
    logic                     r_czero;
    logic [ANG_W-1:0]         r_sang;
    logic [ANG_W-1:0]         r_ang;
    logic                     r_window;
    logic signed [41:0]       r_prod_spd;
    logic signed [40:0]       r_diff;
    logic signed [38:0]       r_plo;
    logic signed [36:0]       r_phi;
    logic signed [57:0]       r_fprod;

    // output registers
    logic [ANG_W-1:0]        r_o_angle;
    logic                    r_o_valid;
    logic signed [SPD_W-1:0] r_o_speed;
    logic signed [SPD_W-1:0] r_o_filt;

    // input conditioning: fold to positive cosine
    logic signed [CORD_W-1:0] s_ext;
    logic signed [CORD_W-1:0] c_ext;
    logic                     c_neg;
    logic [ANG_W-1:0]         sang;

    assign s_ext = {{(CORD_W-IN_W){i_sine_acc[IN_W-1]}}, i_sine_acc};
    assign c_ext = {{(CORD_W-IN_W){i_cosine_acc[IN_W-1]}}, i_cosine_acc};
    assign c_neg = i_cosine_acc[IN_W-1];

    always_comb begin
        if (i_sine_acc > 0) begin
            sang = 17'd65536;
        end else if (i_sine_acc < 0) begin
            sang = 17'd0;
        end else begin
            sang = 17'd32768;
        end
    end

    // one shift-add rotation step
    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    logic signed [Z_W-1:0]    at;

    assign xs = r_x >>> r_iter;
    assign ys = r_y >>> r_iter;
    assign at = Z_W'(atan_units(5'(r_iter)));

    assign o_sts.iter_last = (r_iter == ITER_W'(CORDIC_STEPS - 1));

    // angle offset and clamp
    logic signed [Z_W:0]   z_off;
    logic [ANG_W-1:0]      ang_cordic;
    logic [ANG_W-1:0]      ang;

    assign z_off = {r_z[Z_W-1], r_z} + 19'sd32768;

    always_comb begin
        if (z_off < 0) begin
            ang_cordic = 17'd0;
        end else if (z_off > 19'sd65536) begin
            ang_cordic = 17'd65536;
        end else begin
            ang_cordic = z_off[ANG_W-1:0];
        end
    end

    assign ang = r_czero ? r_sang : ang_cordic;

    // step unwrap over the half turn
    logic signed [18:0] d;
    logic signed [18:0] step;
    logic signed [25:0] sum_raw;
    logic signed [SUM_W-1:0] sum_sat;

    assign d = $signed({2'b00, ang}) - $signed({2'b00, r_prev});

    always_comb begin
        if (d > 19'sd32768) begin
            step = 19'sd65536 - d;
        end else if (d < -19'sd32768) begin
            step = -(19'sd65536 + d);
        end else begin
            step = -d;
        end
    end

    assign sum_raw = {r_sum[SUM_W-1], r_sum} + {{7{step[18]}}, step};

    always_comb begin
        if (sum_raw > 26'sd16777215) begin
            sum_sat = 25'sd16777215;
        end else if (sum_raw < -26'sd16777216) begin
            sum_sat = -25'sd16777216;
        end else begin
            sum_sat = sum_raw[SUM_W-1:0];
        end
    end

    // window count
    logic [WIN_W-1:0] count_next;
    logic [WIN_W-1:0] win;

    assign count_next       = r_count + 8'd1;
    assign win              = (r_window_len == '0) ? 8'd1 : r_window_len;
    assign o_sts.window_hit = (count_next >= win);

    // speed scaling and filter difference
    logic signed [41:0]      spd_sh;
    logic signed [SPD_W-1:0] spd_sat;
    logic signed [40:0]      diff;

    assign spd_sh = r_prod_spd >>> 8;

    always_comb begin
        if (spd_sh > 42'sd4194303) begin
            spd_sat = 23'sd4194303;
        end else if (spd_sh < -42'sd4194304) begin
            spd_sat = -23'sd4194304;
        end else begin
            spd_sat = spd_sh[SPD_W-1:0];
        end
    end

    assign diff = $signed({{2{spd_sat[SPD_W-1]}}, spd_sat, 16'h0000})
                - $signed({r_facc[FACC_W-1], r_facc});

    // filter accumulate with saturation
    logic signed [41:0]       inc;
    logic signed [42:0]       facc_raw;
    logic signed [FACC_W-1:0] facc_sat;

    assign inc      = r_fprod[57:16];
    assign facc_raw = {{3{r_facc[FACC_W-1]}}, r_facc} + {inc[41], inc};

    always_comb begin
        if (facc_raw > 43'sd549755813887) begin
            facc_sat = 40'sd549755813887;
        end else if (facc_raw < -43'sd549755813888) begin
            facc_sat = -40'sd549755813888;
        end else begin
            facc_sat = facc_raw[FACC_W-1:0];
        end
    end

    // integer part of filter state
    logic signed [23:0]      filt_int;
    logic signed [SPD_W-1:0] filt_sat;

    assign filt_int = r_facc[FACC_W-1:16];

    always_comb begin
        if (filt_int > 24'sd4194303) begin
            filt_sat = 23'sd4194303;
        end else if (filt_int < -24'sd4194304) begin
            filt_sat = -23'sd4194304;
        end else begin
            filt_sat = filt_int[SPD_W-1:0];
        end
    end

    // configuration and estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len  <= WINDOW_LEN_RST;
            r_speed_scale <= SPEED_SCALE_RST;
            r_filter_gain <= FILTER_GAIN_RST;
            r_prev        <= '0;
            r_sum         <= '0;
            r_count       <= '0;
            r_speed       <= '0;
            r_facc        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_LEN:  r_window_len  <= i_cfg_data[WIN_W-1:0];
                    CFG_SPEED_SCALE: r_speed_scale <= i_cfg_data;
                    CFG_FILTER_GAIN: r_filter_gain <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.angle_upd) begin
                r_prev  <= ang;
                r_sum   <= sum_sat;
                r_count <= o_sts.window_hit ? '0 : count_next;
            end
            if (i_cmd.spd_upd) begin
                r_speed <= spd_sat;
                r_sum   <= '0;
            end
            if (i_cmd.flt_upd) begin
                r_facc <= facc_sat;
            end
        end
    end

    // working and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= c_neg ? -c_ext : c_ext;
            r_y     <= c_neg ? -s_ext : s_ext;
            r_z     <= '0;
            r_iter  <= '0;
            r_czero <= (i_cosine_acc == '0);
            r_sang  <= sang;
        end
        if (i_cmd.iterate) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else if (r_y < 0) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.angle_upd) begin
            r_ang    <= ang;
            r_window <= o_sts.window_hit;
        end
        if (i_cmd.spd_mul) begin
            r_prod_spd <= 42'(r_sum) * 42'($signed({1'b0, r_speed_scale}));
        end
        if (i_cmd.spd_upd) begin
            r_diff <= diff;
        end
        if (i_cmd.flt_mul) begin
            r_plo <= 39'($signed({1'b0, r_diff[20:0]})) * 39'($signed({1'b0, r_filter_gain}));
            r_phi <= 37'($signed(r_diff[40:21])) * 37'($signed({1'b0, r_filter_gain}));
        end
        if (i_cmd.flt_sum) begin
            r_fprod <= $signed({r_phi, 21'h0}) + {{19{r_plo[38]}}, r_plo};
        end
        if (i_cmd.out_load) begin
            r_o_angle <= r_ang;
            r_o_valid <= r_window;
            r_o_speed <= r_speed;
            r_o_filt  <= filt_sat;
        end
    end

    assign o_angle          = r_o_angle;
    assign o_speed_valid    = r_o_valid;
    assign o_speed          = r_o_speed;
    assign o_speed_filtered = r_o_filt;

endmodule

`default_nettype wire

// ===== design/resolver_angle_speed_estimator_unit.sv =====
// resolver_angle_speed_estimator_unit: top level, joins controller and datapath
// depends on rase_pkg, rase_if, rase_ctrl, rase_dp
//
//   channel    dir  handshake      payload
//   i_item     in   valid/ready    sine_acc, cosine_acc
//   o_result   out  valid/ready    angle, speed_valid, speed, speed_filtered
//   i_cfg      in   valid/ready    index, data (ready always high)
//
// an item passes the load state, the shift-add arctangent loop, which makes
// one rotation per cycle, the angle update and the output state; an item that
// closes a window passes the speed and filter states before the output state
// one result register: the next item is taken while a result waits, and it
// holds in its output state until that result is taken
// synchronous active-low reset restores defaults and clears the estimator state
`default_nettype none

module resolver_angle_speed_estimator_unit import rase_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rase_in_if.sink    i_item,
    rase_out_if.source o_result,
    rase_cfg_if.sink   i_cfg
);

    t_cmd cmd;
    t_sts sts;

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    // sequencing
    rase_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic
    rase_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_sine_acc       (i_item.sine_acc),
        .i_cosine_acc     (i_item.cosine_acc),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_angle          (o_result.angle),
        .o_speed_valid    (o_result.speed_valid),
        .o_speed          (o_result.speed),
        .o_speed_filtered (o_result.speed_filtered)
    );

endmodule

`default_nettype wire

// ===== tb/sv/rase_result_checker.sv =====
// rase_result_checker: watches the sample, result and register channels of the
// resolver angle and speed estimator, predicts each result and compares it
// depends on rase_pkg for widths and register indexes

module rase_result_checker import rase_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_item_valid,
    input  wire logic                   i_item_ready,
    input  wire logic signed [IN_W-1:0] i_sine_acc,
    input  wire logic signed [IN_W-1:0] i_cosine_acc,
    input  wire logic                   i_res_valid,
    input  wire logic                   i_res_ready,
    input  wire logic [ANG_W-1:0]       i_angle,
    input  wire logic                   i_speed_valid,
    input  wire logic [SPD_W-1:0]       i_speed,
    input  wire logic [SPD_W-1:0]       i_speed_filtered,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]   i_cfg_data,
    output logic [31:0]                 o_fail_count,
    output logic [31:0]                 o_pending
);

    // angle units: 65536 is 180 degrees
    localparam longint ANG_HALF = 32768;
    localparam longint ANG_FULL = 65536;
    localparam longint SUM_MAX  = 64'sd16777215;
    localparam longint SUM_MIN  = -64'sd16777216;
    localparam longint SPD_MAX  = 64'sd4194303;
    localparam longint SPD_MIN  = -64'sd4194304;
    localparam longint FACC_MAX = 64'sd549755813887;
    localparam longint FACC_MIN = -64'sd549755813888;

    // rotation angle per vectoring step, atan(2^-i) in angle units
    localparam longint ROT_UNITS [0:23] = '{
        16384, 9672, 5110, 2594, 1302, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        logic [ANG_W-1:0] angle;
        logic             speed_valid;
        logic [SPD_W-1:0] speed;
        logic [SPD_W-1:0] speed_filtered;
    } t_estimate;

    t_estimate angle_speed_q[$];

    // register copies
    logic [WIN_W-1:0]  win_len;
    logic [COEF_W-1:0] spd_scale;
    logic [COEF_W-1:0] flt_gain;

    // estimator state
    longint     prev_ang;
    longint     ang_sum;
    logic [7:0] win_count;
    longint     spd_hold;
    longint     flt_acc;
    int         result_idx;

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // vectoring arctangent on the right half plane, offset by 90 degrees
    function automatic longint resolve_angle(input longint s, input longint c);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int     i;
        z = 0;
        if (c == 0) begin
            if (s > 0) return ANG_FULL;
            if (s < 0) return 0;
            return ANG_HALF;
        end
        x = (c > 0) ? c : -c;
        y = (c > 0) ? s : -s;
        for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ROT_UNITS[i];
            end else if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ROT_UNITS[i];
            end
        end
        return sat(z + ANG_HALF, 0, ANG_FULL);
    endfunction

    // advance the estimator by one sample and queue the result it gives
    task automatic predict_sample(input longint s, input longint c);
        longint    ang;
        longint    d;
        longint    step;
        longint    diff;
        longint    filt;
        longint    win;
        logic      upd;
        t_estimate r;
        upd = 1'b0;
        ang = resolve_angle(s, c);
        d   = ang - prev_ang;
        // unwrap the step over the half turn
        if (d > ANG_HALF)
            step = ANG_FULL - d;
        else if (d < -ANG_HALF)
            step = -(ANG_FULL + d);
        else
            step = -d;
        ang_sum   = sat(ang_sum + step, SUM_MIN, SUM_MAX);
        prev_ang  = ang;
        win_count = win_count + 8'd1;
        win       = (win_len == '0) ? 1 : longint'(win_len);
        // window end: raw speed, then the low-pass filter
        if (longint'(win_count) >= win) begin
            win_count = '0;
            spd_hold  = sat((ang_sum * longint'(spd_scale)) >>> 8, SPD_MIN, SPD_MAX);
            diff      = spd_hold * 65536 - flt_acc;
            flt_acc   = sat(flt_acc + ((diff * longint'(flt_gain)) >>> 16), FACC_MIN, FACC_MAX);
            ang_sum   = 0;
            upd       = 1'b1;
        end
        filt               = sat(flt_acc >>> 16, SPD_MIN, SPD_MAX);
        r.angle            = ang[ANG_W-1:0];
        r.speed_valid      = upd;
        r.speed            = spd_hold[SPD_W-1:0];
        r.speed_filtered   = filt[SPD_W-1:0];
        angle_speed_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("result %0d: %s is %0d, expected %0d", result_idx, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    // compare one accepted result with the oldest estimate
    task automatic check_result();
        t_estimate r;
        if (angle_speed_q.size() == 0) begin
            report_mismatch("unexpected result, angle", longint'(i_angle), -1);
        end else begin
            r = angle_speed_q.pop_front();
            if (i_angle !== r.angle)
                report_mismatch("angle", longint'(i_angle), longint'(r.angle));
            if (i_speed_valid !== r.speed_valid)
                report_mismatch("speed_valid", longint'(i_speed_valid),
                                longint'(r.speed_valid));
            if (i_speed !== r.speed)
                report_mismatch("speed", longint'($signed(i_speed)),
                                longint'($signed(r.speed)));
            if (i_speed_filtered !== r.speed_filtered)
                report_mismatch("speed_filtered", longint'($signed(i_speed_filtered)),
                                longint'($signed(r.speed_filtered)));
        end
        result_idx = result_idx + 1;
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_len      = WINDOW_LEN_RST;
            spd_scale    = SPEED_SCALE_RST;
            flt_gain     = FILTER_GAIN_RST;
            prev_ang     = 0;
            ang_sum      = 0;
            win_count    = '0;
            spd_hold     = 0;
            flt_acc      = 0;
            result_idx   = 0;
            o_fail_count = 0;
            angle_speed_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WINDOW_LEN:  win_len   = i_cfg_data[WIN_W-1:0];
                    CFG_SPEED_SCALE: spd_scale = i_cfg_data[COEF_W-1:0];
                    CFG_FILTER_GAIN: flt_gain  = i_cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end
            // a result taken now belongs to an earlier sample
            if (i_res_valid && i_res_ready)
                check_result();
            if (i_item_valid && i_item_ready)
                predict_sample(longint'(i_sine_acc), longint'(i_cosine_acc));
        end
        o_pending = angle_speed_q.size();
    end

endmodule

// ===== tb/sv/resolver_angle_speed_estimator_unit_test.sv =====
// resolver_angle_speed_estimator_unit_test: drives samples and register writes
// into the estimator with random gaps and result stalls, gives the verdict
// depends on rase_pkg, rase_if, the estimator top level and rase_result_checker

module resolver_angle_speed_estimator_unit_test;
    import rase_pkg::*;

    localparam int  CYCLE_LIMIT     = 1_500_000;
    localparam int  SETTLE_CYCLES   = 40;
    localparam int  PHASE_ITEMS     = 210;
    localparam int  PHASES          = 8;
    localparam real TWO_PI          = 6.283185307179586;
    localparam logic signed [IN_W-1:0] IN_MAX = 24'sh7FFFFF;
    localparam logic signed [IN_W-1:0] IN_MIN = -24'sh800000;

    logic        clk;
    logic        rst_n;
    logic [31:0] fail_count;
    logic [31:0] pending;
    int          cycle_count = 0;
    logic        quiet_phase;
    real         theta;

    rase_in_if  sample_ch ();
    rase_out_if result_ch ();
    rase_cfg_if cfg_ch ();

    resolver_angle_speed_estimator_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (sample_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    rase_result_checker result_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_item_valid     (sample_ch.valid),
        .i_item_ready     (sample_ch.ready),
        .i_sine_acc       (sample_ch.sine_acc),
        .i_cosine_acc     (sample_ch.cosine_acc),
        .i_res_valid      (result_ch.valid),
        .i_res_ready      (result_ch.ready),
        .i_angle          (result_ch.angle),
        .i_speed_valid    (result_ch.speed_valid),
        .i_speed          (result_ch.speed),
        .i_speed_filtered (result_ch.speed_filtered),
        .i_cfg_valid      (cfg_ch.valid),
        .i_cfg_ready      (cfg_ch.ready),
        .i_cfg_index      (cfg_ch.index),
        .i_cfg_data       (cfg_ch.data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // clock
    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // result side stalls
    initial begin : result_stall
        int gap;
        result_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    // one sample item, called at a falling edge
    task automatic send_sample(input logic signed [IN_W-1:0] s,
                               input logic signed [IN_W-1:0] c);
        int gap;
        sample_ch.valid      <= 1'b1;
        sample_ch.sine_acc   <= s;
        sample_ch.cosine_acc <= c;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // hold off until every sample has given its result
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input logic [WIN_W-1:0] win, input logic [COEF_W-1:0] scale,
                             input logic [COEF_W-1:0] gain);
        logic [7:0] junk;
        junk = 8'($urandom);
        wait_idle();
        // upper byte of the window write is ignored by the block
        write_reg(CFG_WINDOW_LEN, {junk, win});
        write_reg(CFG_SPEED_SCALE, scale);
        write_reg(CFG_FILTER_GAIN, gain);
    endtask

    // a stretch of a vector turning at a steady rate
    task automatic send_rotation(input int count, input real step, input real amp);
        int n;
        logic signed [IN_W-1:0] s;
        logic signed [IN_W-1:0] c;
        for (n = 0; n < count; n++) begin
            theta = theta + step;
            if (theta > TWO_PI) theta = theta - TWO_PI;
            if (theta < -TWO_PI) theta = theta + TWO_PI;
            s = IN_W'($rtoi(amp * $sin(theta)));
            c = IN_W'($rtoi(amp * $cos(theta)));
            send_sample(s, c);
        end
    endtask

    // random part of one phase: mostly rotations, some noise, zero-cosine samples and corner values
    task automatic run_phase(input int items);
        int          remaining;
        int          kind;
        int          len;
        int          r;
        real         step;
        real         amp;
        logic [31:0] raw_s;
        logic [31:0] raw_c;
        logic signed [IN_W-1:0] picks [0:4];
        picks = '{IN_MAX, IN_MIN, 24'sd0, 24'sd1, -24'sd1};
        remaining = items;
        while (remaining > 0) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                len  = $urandom_range(5, 40);
                step = real'(int'($urandom_range(0, 62000)) - 31000) / 10000.0;
                r    = $urandom_range(0, 99);
                if (r < 15)
                    amp = real'($urandom_range(1, 200));
                else if (r < 30)
                    amp = 8388607.0;
                else
                    amp = real'($urandom_range(1000, 8388607));
                send_rotation(len, step, amp);
                remaining = remaining - len;
            end else if (kind < 90) begin
                raw_s = $urandom;
                raw_c = $urandom;
                send_sample(raw_s[IN_W-1:0], raw_c[IN_W-1:0]);
                remaining = remaining - 1;
            end else if (kind < 95) begin
                // zero cosine, sine of either sign or zero
                raw_s = $urandom;
                if ($urandom_range(0, 3) == 0)
                    raw_s = '0;
                send_sample(raw_s[IN_W-1:0], '0);
                remaining = remaining - 1;
            end else begin
                send_sample(picks[$urandom_range(0, 4)], picks[$urandom_range(0, 4)]);
                remaining = remaining - 1;
            end
        end
    endtask

    // stimulus
    initial begin : stimulus
        logic [WIN_W-1:0]  win_set   [0:PHASES-1];
        logic [COEF_W-1:0] scale_set [0:PHASES-1];
        logic [COEF_W-1:0] gain_set  [0:PHASES-1];
        int                p;
        win_set   = '{8'd1, 8'd255, 8'd0, 8'd20, 8'd0, 8'd0, 8'd0, 8'd0};
        scale_set = '{16'd65535, 16'd65535, 16'd0, 16'd125, 16'd0, 16'd0, 16'd0, 16'd0};
        gain_set  = '{16'd65535, 16'd0, 16'd1311, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0};
        for (p = 4; p < PHASES; p++) begin
            win_set[p]   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                        : 8'($urandom_range(1, 40));
            scale_set[p] = 16'($urandom_range(0, 65535));
            gain_set[p]  = 16'($urandom_range(0, 65535));
        end

        rst_n                = 1'b0;
        quiet_phase          = 1'b0;
        theta                = 0.0;
        sample_ch.valid      = 1'b0;
        sample_ch.sine_acc   = '0;
        sample_ch.cosine_acc = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_WINDOW_LEN;
        cfg_ch.data          = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: first sample with both inputs zero, then zero cosine and extremes
        send_sample(24'sd0, 24'sd0);
        send_sample(24'sd1, 24'sd0);
        send_sample(-24'sd1, 24'sd0);
        send_sample(IN_MAX, 24'sd0);
        send_sample(IN_MIN, 24'sd0);
        send_sample(24'sd0, IN_MAX);
        send_sample(24'sd0, IN_MIN);
        send_sample(IN_MAX, IN_MAX);
        send_sample(IN_MIN, IN_MIN);
        send_sample(IN_MAX, IN_MIN);
        send_sample(IN_MIN, IN_MAX);
        send_sample(24'sd1, 24'sd1);
        send_sample(-24'sd1, 24'sd1);
        send_sample(24'sd1, -24'sd1);
        send_sample(IN_MAX, 24'sd1);
        send_sample(24'sd1, IN_MAX);
        send_sample(IN_MIN, 24'sd1);
        send_sample(-24'sd1, IN_MIN);
        send_sample(24'sd5, 24'sd3);
        send_sample(-24'sd7, 24'sd9);
        send_sample(24'sd1000, -24'sd2);
        send_sample(-24'sd3, -24'sd4000);
        send_sample(24'sd12345, 24'sd54321);

        // window lowered below the running count closes on the next sample
        configure(8'd2, SPEED_SCALE_RST, FILTER_GAIN_RST);
        send_sample(24'sd100, 24'sd200);
        // zero window length behaves as one
        configure(8'd0, SPEED_SCALE_RST, FILTER_GAIN_RST);
        send_sample(-24'sd300, 24'sd50);

        // random phases over several register settings
        for (p = 0; p < PHASES; p++) begin
            configure(win_set[p], scale_set[p], gain_set[p]);
            quiet_phase = (p % 3 == 1);
            run_phase(PHASE_ITEMS);
        end

        // drain and settle
        quiet_phase = 1'b0;
        sample_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
